[rtl/pli_pkg.sv]
package pli_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_W     = 5;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [3:0]               entry_index;
    logic signed [DATA_W-1:0] entry_x;
    logic signed [DATA_W-1:0] entry_y;
    logic signed [DATA_W-1:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_y;
    logic                     zero_span_error;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_entry;
    logic cap_query;
    logic rd_x;
    logic decide;
    logic rd_ya;
    logic rd_yb;
    logic prep;
    logic mul;
    logic div_step;
    logic fin;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic direct;
  } sts_t;

endpackage

[rtl/piecewise_linear_table_interp.sv]
// Piecewise linear lookup over a table of up to MAX_POINTS (x, y) breakpoints in
// signed Q16.16, x ascending. Raise start with a beat on item_i while busy is low:
// a write beat (mode 0) stores one breakpoint in the cycle it is taken, gives no
// result and leaves busy low; a query beat (mode 1) returns exactly one result.
// A query holds busy while it scans the breakpoints in use, then ends without the
// divide when the answer is clamped to an end of the table, the chosen segment has
// zero span or does not hold the query, and runs the multiply and divide otherwise.
// The table has one read port and is scanned one breakpoint per cycle; the
// divide is a restoring divider that retires one quotient bit per cycle. The
// result is shown on result_o for one cycle with result_valid_o high, in the
// cycle in which busy falls; the receiver cannot stall it, so sample it then.
// Table entries are undefined until written: write every slot a query can touch
// first. Write points_in_use through cfg_we_i/cfg_wdata_i only while the block
// is idle; counts below 2 act as 2 and counts above MAX_POINTS act as MAX_POINTS.
module piecewise_linear_table_interp #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  pli_pkg::in_item_t             item_i,
  input  logic                          cfg_we_i,
  input  logic [pli_pkg::CFG_W-1:0]     cfg_wdata_i,
  output pli_pkg::out_item_t            result_o,
  output logic                          result_valid_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  logic [pli_pkg::CFG_W-1:0] points_q;
  logic [AW-1:0]             last_idx;
  logic [AW-1:0]             rd_addr;
  pli_pkg::cmd_t             cmd;
  pli_pkg::sts_t             sts;

  // points_in_use register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= pli_pkg::CFG_W'(2);
    end else if (cfg_we_i) begin
      points_q <= cfg_wdata_i;
    end
  end

  // index of the last breakpoint in use, count clamped to the legal range
  always_comb begin
    if (points_q < pli_pkg::CFG_W'(2)) begin
      last_idx = AW'(1);
    end else if (32'(points_q) > 32'(MAX_POINTS)) begin
      last_idx = AW'(MAX_POINTS - 1);
    end else begin
      last_idx = AW'(points_q - pli_pkg::CFG_W'(1));
    end
  end

  pli_ctrl #(
    .AW(AW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .mode_i    (item_i.mode),
    .last_idx_i(last_idx),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr),
    .busy_o    (busy),
    .done_o    (result_valid_o)
  );

  pli_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .item_i    (item_i),
    .rd_addr_i (rd_addr),
    .last_idx_i(last_idx),
    .sts_o     (sts),
    .result_o  (result_o)
  );

endmodule

[rtl/pli_datapath.sv]
module pli_datapath #(
  parameter int unsigned MAX_POINTS = 16,
  localparam int unsigned AW = $clog2(MAX_POINTS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pli_pkg::cmd_t       cmd_i,
  input  pli_pkg::in_item_t   item_i,
  input  logic [AW-1:0]       rd_addr_i,
  input  logic [AW-1:0]       last_idx_i,
  output pli_pkg::sts_t       sts_o,
  output pli_pkg::out_item_t  result_o
);

  // breakpoint storage
  logic signed [31:0] x_mem [MAX_POINTS];
  logic signed [31:0] y_mem [MAX_POINTS];

  logic               wr_ok;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      y_addr;

  logic signed [31:0] rdx_q;
  logic signed [31:0] rdy_q;
  logic [AW-1:0]      rdx_idx_q;
  logic               chk_q;

  logic signed [31:0] q_q;
  logic signed [31:0] prev_q;
  logic signed [31:0] xfirst_q;
  logic signed [31:0] xlast_q;
  logic signed [31:0] xs0_q;
  logic signed [31:0] xs1_q;
  logic               match_q;
  logic [AW-1:0]      seg_q;

  logic               clamp_q;
  logic [AW-1:0]      ya_q;
  logic [AW-1:0]      yb_q;
  logic signed [31:0] x0_q;
  logic signed [31:0] x1_q;
  logic signed [31:0] y0_q;

  logic [31:0]        dx_q;
  logic [31:0]        t_q;
  logic [31:0]        mag_q;
  logic               neg_q;
  logic [31:0]        rem_q;
  logic [31:0]        quo_q;

  logic signed [31:0] res_q;
  logic               err_q;

  logic               span_zero;
  logic               outside;
  logic               direct;
  logic [32:0]        dx_full;
  logic [32:0]        t_full;
  logic [32:0]        dy_full;
  logic [32:0]        mag_full;
  logic [63:0]        prod;
  logic [32:0]        trial;
  logic [32:0]        diff;
  logic               ge;
  logic [33:0]        ysum;
  logic [31:0]        ysat;

  assign wr_ok   = ({28'd0, item_i.entry_index} < 32'(MAX_POINTS));
  assign wr_addr = AW'(item_i.entry_index);
  assign y_addr  = cmd_i.rd_yb ? yb_q : ya_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry && wr_ok) begin
      x_mem[wr_addr] <= item_i.entry_x;
      y_mem[wr_addr] <= item_i.entry_y;
    end
    if (cmd_i.rd_x) begin
      rdx_q <= x_mem[rd_addr_i];
    end
    if (cmd_i.rd_ya || cmd_i.rd_yb) begin
      rdy_q <= y_mem[y_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q <= 1'b0;
    end else begin
      chk_q <= cmd_i.rd_x;
    end
  end

  assign span_zero = (x0_q == x1_q);
  assign outside   = (q_q < x0_q) || (q_q > x1_q);
  assign direct    = clamp_q || span_zero || outside;

  assign dx_full  = {x1_q[31], x1_q} - {x0_q[31], x0_q};
  assign t_full   = {q_q[31], q_q} - {x0_q[31], x0_q};
  assign dy_full  = {rdy_q[31], rdy_q} - {y0_q[31], y0_q};
  assign mag_full = dy_full[32] ? (33'd0 - dy_full) : dy_full;

  assign prod = 64'(mag_q) * 64'(t_q);

  // one restoring step: the high half stays below the divisor throughout
  assign trial = {rem_q, quo_q[31]};
  assign diff  = trial - {1'b0, dx_q};
  assign ge    = (trial >= {1'b0, dx_q});

  assign ysum = neg_q ? ({{2{y0_q[31]}}, y0_q} - {2'b00, quo_q})
                      : ({{2{y0_q[31]}}, y0_q} + {2'b00, quo_q});

  always_comb begin
    if ((ysum[33:31] == 3'b000) || (ysum[33:31] == 3'b111)) begin
      ysat = ysum[31:0];
    end else if (ysum[33]) begin
      ysat = 32'h8000_0000;
    end else begin
      ysat = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_x) begin
      rdx_idx_q <= rd_addr_i;
    end
    if (cmd_i.cap_query) begin
      q_q     <= item_i.query_x;
      match_q <= 1'b0;
    end
    // scan one breakpoint per cycle; the last matching segment wins
    if (chk_q) begin
      if (rdx_idx_q == '0) begin
        xfirst_q <= rdx_q;
      end else if ((q_q >= prev_q) && (q_q <= rdx_q)) begin
        match_q <= 1'b1;
        seg_q   <= rdx_idx_q - AW'(1);
        xs0_q   <= prev_q;
        xs1_q   <= rdx_q;
      end
      prev_q <= rdx_q;
      if (rdx_idx_q == last_idx_i) begin
        xlast_q <= rdx_q;
      end
    end
    if (cmd_i.decide) begin
      if (q_q > xlast_q) begin
        clamp_q <= 1'b1;
        ya_q    <= last_idx_i;
      end else if (q_q < xfirst_q) begin
        clamp_q <= 1'b1;
        ya_q    <= '0;
      end else begin
        clamp_q <= 1'b0;
        if (match_q) begin
          ya_q <= seg_q;
          yb_q <= seg_q + AW'(1);
          x0_q <= xs0_q;
          x1_q <= xs1_q;
        end else begin
          ya_q <= '0;
          yb_q <= last_idx_i;
          x0_q <= xfirst_q;
          x1_q <= xlast_q;
        end
      end
    end
    if (cmd_i.rd_yb) begin
      y0_q <= rdy_q;
    end
    if (cmd_i.prep) begin
      if (direct) begin
        res_q <= y0_q;
        err_q <= !clamp_q && span_zero;
      end else begin
        dx_q  <= dx_full[31:0];
        t_q   <= t_full[31:0];
        mag_q <= mag_full[31:0];
        neg_q <= dy_full[32];
      end
    end
    if (cmd_i.mul) begin
      rem_q <= prod[63:32];
      quo_q <= prod[31:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      quo_q <= {quo_q[30:0], ge};
    end
    if (cmd_i.fin) begin
      res_q <= ysat;
      err_q <= 1'b0;
    end
  end

  assign sts_o.direct = direct;

  assign result_o.result_y        = res_q;
  assign result_o.zero_span_error = err_q;

endmodule

[rtl/pli_ctrl.sv]
module pli_ctrl #(
  parameter int unsigned AW = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           mode_i,
  input  logic [AW-1:0]  last_idx_i,
  input  pli_pkg::sts_t  sts_i,
  output pli_pkg::cmd_t  cmd_o,
  output logic [AW-1:0]  rd_addr_o,
  output logic           busy_o,
  output logic           done_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_DECIDE,
    S_YA,
    S_YB,
    S_PREP,
    S_MUL,
    S_DIV,
    S_FIN
  } state_e;

  state_e                      state_q;
  logic [AW-1:0]               k_q;
  logic [pli_pkg::CNT_W-1:0]   cnt_q;
  logic                        done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i && (mode_i == pli_pkg::MODE_QUERY)) begin
            k_q     <= '0;
            state_q <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          k_q <= k_q + AW'(1);
          if (k_q == last_idx_i) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN:  state_q <= S_DECIDE;
        S_DECIDE: state_q <= S_YA;
        S_YA:     state_q <= S_YB;
        S_YB:     state_q <= S_PREP;
        S_PREP: begin
          if (sts_i.direct) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + pli_pkg::CNT_W'(1);
          if (cnt_q == pli_pkg::LAST_STEP) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.wr_entry  = start_i && (mode_i == pli_pkg::MODE_WRITE);
        cmd_o.cap_query = start_i && (mode_i == pli_pkg::MODE_QUERY);
      end
      S_SWEEP:  cmd_o.rd_x     = 1'b1;
      S_DECIDE: cmd_o.decide   = 1'b1;
      S_YA:     cmd_o.rd_ya    = 1'b1;
      S_YB:     cmd_o.rd_yb    = 1'b1;
      S_PREP:   cmd_o.prep     = 1'b1;
      S_MUL:    cmd_o.mul      = 1'b1;
      S_DIV:    cmd_o.div_step = 1'b1;
      S_FIN:    cmd_o.fin      = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

  assign rd_addr_o = k_q;
  assign busy_o    = (state_q != S_IDLE);
  assign done_o    = done_q;

endmodule

[bench/piecewise_linear_table_interp_tb.sv]
`timescale 1ns / 1ps

module piecewise_linear_table_interp_tb;

  localparam int unsigned NUM_SLOTS     = 16;
  localparam int unsigned TARGET_ITEMS  = 450;
  // Longer than the longest time a query holds busy, rounded up for the drain.
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam longint      Y_MAX         = 64'sd2147483647;
  localparam longint      Y_MIN         = -64'sd2147483648;

  // One entry of the stimulus queue: either a register write or an item beat,
  // with the number of idle cycles the sender inserts before offering it.
  typedef struct packed {
    logic                      is_cfg;
    logic [pli_pkg::CFG_W-1:0] cfg_val;
    logic [4:0]                gap;
    pli_pkg::in_item_t         item;
  } beat_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      start       = 1'b0;
  logic                      busy;
  pli_pkg::in_item_t         item_i      = '0;
  logic                      cfg_we_i    = 1'b0;
  logic [pli_pkg::CFG_W-1:0] cfg_wdata_i = '0;
  pli_pkg::out_item_t        result_o;
  logic                      result_valid_o;

  // Stimulus side
  beat_t       beat_q[$];
  longint      gen_x [NUM_SLOTS];
  longint      gen_y [NUM_SLOTS];
  int unsigned gen_n     = 2;
  int unsigned item_cnt  = 0;
  bit          burst     = 1'b0;
  logic [pli_pkg::CFG_W-1:0] cfg_plan [7] =
    '{5'd0, 5'd31, 5'd1, 5'd17, 5'd2, 5'd16, 5'd3};

  // Predictor state: the table and point count as the block should hold them
  logic signed [pli_pkg::DATA_W-1:0] pt_x [NUM_SLOTS];
  logic signed [pli_pkg::DATA_W-1:0] pt_y [NUM_SLOTS];
  logic [pli_pkg::CFG_W-1:0]         pts_cfg = 5'd2;
  pli_pkg::out_item_t                pending_answers[$];

  // Driver and checker bookkeeping
  int unsigned        drv_wait  = 0;
  int unsigned        idle_run  = 0;
  int unsigned        cycle_cnt = 0;
  int unsigned        fail_cnt  = 0;
  logic               beat_open;
  logic               start_nxt;
  logic               we_nxt;
  beat_t              head;
  pli_pkg::out_item_t want;

  piecewise_linear_table_interp #(
    .MAX_POINTS(NUM_SLOTS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  always #1 clk_i = ~clk_i;

  // Expected answer of one query against the current table and point count.
  function automatic pli_pkg::out_item_t interp_answer(
    logic signed [pli_pkg::DATA_W-1:0] qx);
    int unsigned        n;
    int unsigned        lo_i;
    int unsigned        hi_i;
    longint             q, x0, x1, y0, y1, y;
    bit [63:0]          dx, t, mag, quo;
    pli_pkg::out_item_t res;
    n = pts_cfg;
    if (n < 2) n = 2;
    if (n > NUM_SLOTS) n = NUM_SLOTS;
    q = qx;
    res.zero_span_error = 1'b0;
    // Clamp above first: it wins over the below test on an unsorted table.
    if (q > pt_x[n-1]) begin
      y = pt_y[n-1];
    end else if (q < pt_x[0]) begin
      y = pt_y[0];
    end else begin
      // Fall back to first-to-last; the highest matching segment wins.
      lo_i = 0;
      hi_i = n - 1;
      for (int i = 0; i + 1 < n; i++) begin
        if (q >= pt_x[i] && q <= pt_x[i+1]) begin
          lo_i = i;
          hi_i = i + 1;
        end
      end
      x0 = pt_x[lo_i];
      x1 = pt_x[hi_i];
      y0 = pt_y[lo_i];
      y1 = pt_y[hi_i];
      if (x1 == x0 || q < x0 || q > x1) begin
        y = y0;
        res.zero_span_error = (x1 == x0);
      end else begin
        // Both factors stay below 2^32, so the 64-bit product is exact.
        dx  = x1 - x0;
        t   = q - x0;
        mag = (y1 < y0) ? y0 - y1 : y1 - y0;
        quo = (mag * t) / dx;
        y   = (y1 < y0) ? y0 - $signed(quo) : y0 + $signed(quo);
      end
    end
    if (y > Y_MAX) y = Y_MAX;
    if (y < Y_MIN) y = Y_MIN;
    res.result_y = y[31:0];
    return res;
  endfunction

  function automatic longint rand_s32();
    logic signed [31:0] v;
    v = $urandom;
    return v;
  endfunction

  function automatic longint pick_between(longint lo, longint hi);
    bit [63:0] span;
    bit [63:0] r;
    span = hi - lo + 1;
    r    = {$urandom, $urandom};
    return lo + $signed(r % span);
  endfunction

  task automatic push_write(int unsigned idx, longint xv, longint yv);
    beat_t b;
    b.is_cfg            = 1'b0;
    b.cfg_val           = pli_pkg::CFG_W'($urandom);
    b.gap               = burst ? 5'd0 : 5'($urandom_range(0, 19));
    b.item.mode         = pli_pkg::MODE_WRITE;
    b.item.entry_index  = idx[3:0];
    b.item.entry_x      = xv[31:0];
    b.item.entry_y      = yv[31:0];
    b.item.query_x      = $urandom;
    beat_q.push_back(b);
    gen_x[idx] = xv;
    gen_y[idx] = yv;
    item_cnt++;
  endtask

  task automatic push_query(longint qv);
    beat_t b;
    b.is_cfg            = 1'b0;
    b.cfg_val           = pli_pkg::CFG_W'($urandom);
    b.gap               = burst ? 5'd0 : 5'($urandom_range(0, 19));
    b.item.mode         = pli_pkg::MODE_QUERY;
    b.item.entry_index  = 4'($urandom);
    b.item.entry_x      = $urandom;
    b.item.entry_y      = $urandom;
    b.item.query_x      = qv[31:0];
    beat_q.push_back(b);
    item_cnt++;
  endtask

  task automatic push_cfg(logic [pli_pkg::CFG_W-1:0] val);
    beat_t b;
    b         = '0;
    b.is_cfg  = 1'b1;
    b.cfg_val = val;
    beat_q.push_back(b);
    gen_n = (val < 2) ? 2 : ((val > NUM_SLOTS) ? NUM_SLOTS : val);
  endtask

  // One phase: new point count, a freshly shaped table, then a run of queries.
  task automatic run_phase(logic [pli_pkg::CFG_W-1:0] cfg_val);
    int unsigned shape;
    int unsigned n_q;
    int unsigned step_max;
    int unsigned pick;
    int unsigned k;
    longint      cur;
    longint      lo;
    longint      hi;
    longint      qv;
    burst = ($urandom_range(0, 3) == 0);
    push_cfg(cfg_val);
    shape = $urandom_range(0, 9);
    if (shape <= 7) begin
      // Ascending x; about one step in six is zero to create zero-span segments.
      if (shape <= 5) begin
        step_max = 32'hFFFF_FFFF / gen_n;
        cur      = -64'sd2147483648 + $urandom_range(0, step_max);
      end else begin
        step_max = $urandom_range(1, 4000);
        cur      = pick_between(-64'sd2147483648, 64'sd2147483647 - 64000);
      end
      for (int i = 0; i < gen_n; i++) begin
        if (i != 0 && $urandom_range(0, 5) != 0) cur += $urandom_range(0, step_max);
        push_write(i, cur, rand_s32());
      end
      // Noise: slots past the count must not affect answers.
      if (gen_n < NUM_SLOTS && $urandom_range(0, 2) == 0) begin
        push_write($urandom_range(gen_n, NUM_SLOTS - 1), rand_s32(), rand_s32());
      end
    end else if (shape == 8) begin
      for (int i = 0; i < gen_n; i++) push_write(i, rand_s32(), rand_s32());
    end else begin
      repeat ($urandom_range(0, 3)) begin
        push_write($urandom_range(0, NUM_SLOTS - 1), rand_s32(), rand_s32());
      end
    end

    n_q = $urandom_range(12, 24);
    repeat (n_q) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        k  = $urandom_range(0, gen_n - 2);
        lo = (gen_x[k] < gen_x[k+1]) ? gen_x[k] : gen_x[k+1];
        hi = (gen_x[k] < gen_x[k+1]) ? gen_x[k+1] : gen_x[k];
        qv = pick_between(lo, hi);
      end else if (pick == 6) begin
        qv = gen_x[$urandom_range(0, gen_n - 1)];
      end else if (pick == 7) begin
        qv = $urandom_range(0, 1) ? gen_x[0] - 1 : gen_x[gen_n-1] + 1;
        if (qv > Y_MAX || qv < Y_MIN) qv = rand_s32();
      end else begin
        qv = rand_s32();
      end
      push_query(qv);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    int unsigned p;
    // Zero span at the reset point count: a query at the shared x flags it,
    // one below and one above clamp to the end values.
    burst = 1'b0;
    push_write(0, 100, -5);
    push_write(1, 100, 7);
    push_query(100);
    push_query(99);
    push_query(101);
    // Fill every slot: x spans the whole 32-bit range, y swings rail to rail so
    // each segment has the largest rise or fall the format allows.
    for (int i = 0; i < NUM_SLOTS; i++) begin
      push_write(i, -64'sd2147483648 + longint'(i) * 286331153,
                 (i % 2) ? Y_MAX : Y_MIN);
    end
    push_cfg(5'd16);
    push_query(-64'sd2147483648);
    push_query(64'sd2147483647);
    push_query(gen_x[7] + 143165576);
    push_query(gen_x[8]);
    push_query(gen_x[3] + 1);

    p = 0;
    while (item_cnt < TARGET_ITEMS) begin
      run_phase((p < 7) ? cfg_plan[p] : pli_pkg::CFG_W'($urandom_range(0, 31)));
      p++;
    end

    // Drain: every beat taken and every answer back, then watch for strays.
    while (beat_q.size() != 0 || start || pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_answers.size() != 0) begin
      $error("%0d answers never arrived", pending_answers.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("piecewise_linear_table_interp_tb: PASS");
    end else begin
      $display("piecewise_linear_table_interp_tb: FAIL");
    end
    $finish;
  end

  // Driver: offer beats from the queue, predict on acceptance, and write the
  // point count only after the block has been idle for the full settle time.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) pts_cfg = cfg_wdata_i;
      beat_open = start;
      if (start && !busy) begin
        if (item_i.mode == pli_pkg::MODE_QUERY) begin
          pending_answers.push_back(interp_answer(item_i.query_x));
        end else if (item_i.entry_index < NUM_SLOTS) begin
          pt_x[item_i.entry_index] = item_i.entry_x;
          pt_y[item_i.entry_index] = item_i.entry_y;
        end
        beat_open = 1'b0;
      end
      start_nxt = beat_open;
      we_nxt    = 1'b0;
      if (pending_answers.size() == 0 && !busy) idle_run++;
      else idle_run = 0;
      // Hold an open beat; otherwise count down the gap, then take the head.
      if (!beat_open && beat_q.size() != 0) begin
        if (drv_wait != 0) begin
          drv_wait--;
        end else if (beat_q[0].is_cfg) begin
          if (idle_run >= SETTLE_CYCLES) begin
            we_nxt = 1'b1;
            cfg_wdata_i <= beat_q[0].cfg_val;
            void'(beat_q.pop_front());
            idle_run = 0;
          end
        end else if (beat_q[0].gap != 0) begin
          head     = beat_q.pop_front();
          drv_wait = head.gap;
          head.gap = '0;
          beat_q.push_front(head);
        end else begin
          head = beat_q.pop_front();
          item_i   <= head.item;
          start_nxt = 1'b1;
        end
      end
      start    <= start_nxt;
      cfg_we_i <= we_nxt;
    end
  end

  // Monitor: a result lasts one cycle and cannot be stalled, so take it now.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_answers.size() == 0) begin
        $error("result_y: no query pending, got %0d", result_o.result_y);
        fail_cnt++;
      end else begin
        want = pending_answers.pop_front();
        if (result_o.result_y !== want.result_y) begin
          $error("result_y: expected %0d, got %0d", want.result_y, result_o.result_y);
          fail_cnt++;
        end
        if (result_o.zero_span_error !== want.zero_span_error) begin
          $error("zero_span_error: expected %0b, got %0b",
                 want.zero_span_error, result_o.zero_span_error);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("piecewise_linear_table_interp_tb: FAIL");
      $finish;
    end
  end

endmodule

[filelist.f]
rtl/pli_pkg.sv
rtl/pli_datapath.sv
rtl/pli_ctrl.sv
rtl/piecewise_linear_table_interp.sv
bench/piecewise_linear_table_interp_tb.sv
